// File: rtl/core/sha512_pkg.sv
// shared types, constants and round functions for the sha-512 engine
package sha512_pkg;

  localparam int SchedDepth = 16;
  localparam int Rounds = 80;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } out_item_t;

  localparam logic [63:0] PadWord = 64'h8000000000000000;

  function automatic logic [63:0] init_hash(input logic [2:0] i);
    logic [63:0] r;
    case (i)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] t);
    logic [63:0] r;
    case (t)
      7'd0: r = 64'h428a2f98d728ae22; 7'd1: r = 64'h7137449123ef65cd;
      7'd2: r = 64'hb5c0fbcfec4d3b2f; 7'd3: r = 64'he9b5dba58189dbbc;
      7'd4: r = 64'h3956c25bf348b538; 7'd5: r = 64'h59f111f1b605d019;
      7'd6: r = 64'h923f82a4af194f9b; 7'd7: r = 64'hab1c5ed5da6d8118;
      7'd8: r = 64'hd807aa98a3030242; 7'd9: r = 64'h12835b0145706fbe;
      7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
      7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
      7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
      7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
      7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
      7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
      7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
      7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
      7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
      7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
      7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
      7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
      7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
      7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
      7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
      7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
      7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
      7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
      7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
      7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
      7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
      7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
      7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
      7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
      7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
      7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
      7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
      7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
      7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
      7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
      7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
      7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
      7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
      7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
      7'd78: r = 64'h5fcb6fab3ad6faec;
      default: r = 64'h6c44198c4a475817;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] v, input int s);
    return (v >> s) | (v << (64 - s));
  endfunction

  function automatic logic [63:0] bsig0(input logic [63:0] v);
    return rotr(v, 28) ^ rotr(v, 34) ^ rotr(v, 39);
  endfunction
  function automatic logic [63:0] bsig1(input logic [63:0] v);
    return rotr(v, 14) ^ rotr(v, 18) ^ rotr(v, 41);
  endfunction
  function automatic logic [63:0] ssig0(input logic [63:0] v);
    return rotr(v, 1) ^ rotr(v, 8) ^ (v >> 7);
  endfunction
  function automatic logic [63:0] ssig1(input logic [63:0] v);
    return rotr(v, 19) ^ rotr(v, 61) ^ (v >> 6);
  endfunction

endpackage

// File: rtl/core/sha512_ram.sv
// generic single-write ram with two registered read ports
module sha512_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  output logic [Width-1:0]         rdata_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  // write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/sha512_sched.sv
// message schedule: 16-word memory, one expanded word per round slot
module sha512_sched (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [63:0] push_word,
  input  logic        step,
  input  logic [6:0]  round,
  input  logic [1:0]  phase,
  output logic [63:0] wt
);

  logic        we;
  logic [3:0]  waddr;
  logic [63:0] wdata;
  logic [3:0]  raddr_a, raddr_b;
  logic [63:0] rdata_a, rdata_b;
  logic [3:0]  wpos;
  logic [63:0] acc;

  sha512_ram #(.Width(64), .Depth(sha512_pkg::SchedDepth)) u_ram (
    .clk, .we, .waddr, .wdata,
    .raddr_a, .rdata_a, .raddr_b, .rdata_b
  );

  // phase 0 reads w[t-2], w[t-7]; phase 1 reads w[t-15], w[t-16]
  always_comb begin
    if (phase == 2'd0) begin
      raddr_a = round[3:0] - 4'd2;
      raddr_b = round[3:0] - 4'd7;
    end else begin
      raddr_a = round[3:0] - 4'd15;
      raddr_b = round[3:0];
    end
  end

  // write-back: input words while gathering, expanded words during rounds
  always_comb begin
    we    = 1'b0;
    waddr = wpos;
    wdata = push_word;
    if (push) begin
      we = 1'b1;
    end else if (step && round >= 7'd16) begin
      we    = 1'b1;
      waddr = round[3:0];
      wdata = wt;
    end
  end

  // phase 1 holds s1(w-2)+w-7; phase 2 finishes the sum
  always_ff @(posedge clk) begin
    if (phase == 2'd1) begin
      acc <= sha512_pkg::ssig1(rdata_a) + rdata_b;
    end
    if (phase == 2'd2) begin
      if (round >= 7'd16) begin
        wt <= acc + sha512_pkg::ssig0(rdata_a) + rdata_b;
      end else begin
        wt <= rdata_b;
      end
    end
  end

  // gather position
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos <= '0;
    end else if (push) begin
      wpos <= wpos + 4'd1;
    end
  end

endmodule

// File: rtl/core/sha512_hash_engine.sv
// sha-512 engine top level: word gathering, padding, round unit and digest out
// a block is 16 words at one per cycle while in_ready is high, then 80 rounds
// and a hash update; no new words are taken until the block is through
// a last word fills its block with padding at one word per cycle, then one or
// two compressions, then 8 digest items, one per cycle while out_ready is high
// synchronous active-high reset returns to the initial hash, empty message
module sha512_hash_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha512_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha512_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    S_GATHER, S_PAD, S_ROUND, S_FINAL, S_OUT
  } state_t;

  state_t      state;
  logic [3:0]  pos;
  logic [6:0]  round;
  logic [1:0]  phase;
  logic [63:0] bit_count;
  logic [63:0] hash [8];
  logic [63:0] v [8];
  logic        pad_late;
  logic        pad_len_pending;
  logic        pad_marker_pending;
  logic        finishing;
  logic [2:0]  out_idx;
  logic [63:0] t1_part;

  logic        push;
  logic [63:0] push_word;
  logic        step;
  logic [63:0] wt;
  logic [3:0]  nb;
  logic [63:0] keep;
  logic [63:0] last_word;
  logic [63:0] t1, t2;

  sha512_sched u_sched (
    .clk, .rst, .push, .push_word, .step,
    .round, .phase, .wt
  );

  // clamp the byte count and build the padded final word
  always_comb begin
    nb = (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;
    keep = (nb == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {nb[3:0], 3'b000});
    if (nb == 4'd8) begin
      last_word = in_data.data_word;
    end else begin
      last_word = (in_data.data_word & keep) |
                  (64'h80 << (7'd56 - {nb[2:0], 3'b000}));
    end
  end

  assign in_ready = (state == S_GATHER);
  assign step     = (state == S_ROUND) && (phase == 2'd3);

  // word to the schedule memory; length goes in slot 15 once the marker sits at 13 or below
  always_comb begin
    push      = 1'b0;
    push_word = 64'd0;
    if (state == S_GATHER && in_valid) begin
      push      = 1'b1;
      push_word = in_data.last ? last_word : in_data.data_word;
    end else if (state == S_PAD) begin
      push = 1'b1;
      if (pad_marker_pending) begin
        push_word = sha512_pkg::PadWord;
      end else if (pos == 4'd15 && !pad_late) begin
        push_word = bit_count;
      end
    end
  end

  // round function, h + s1 + ch + k is registered in the cycle before the round step
  always_comb begin
    t1 = t1_part + wt;
    t2 = sha512_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign out_valid            = (state == S_OUT);
  assign out_data.digest_word = hash[out_idx];
  assign out_data.word_index  = out_idx;
  assign out_data.digest_last = (out_idx == 3'd7);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_GATHER;
      pos                <= '0;
      round              <= '0;
      phase              <= '0;
      bit_count          <= '0;
      pad_marker_pending <= 1'b0;
      pad_len_pending    <= 1'b0;
      pad_late           <= 1'b0;
      finishing          <= 1'b0;
      out_idx            <= '0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= sha512_pkg::init_hash(3'(i));
      end
    end else begin
      unique case (state)
        S_GATHER: begin
          if (in_valid) begin
            pos <= pos + 4'd1;
            if (in_data.last) begin
              bit_count          <= bit_count + {57'd0, nb, 3'b000};
              finishing          <= 1'b1;
              pad_marker_pending <= (nb == 4'd8);
              pad_len_pending    <= 1'b1;
              pad_late           <= (nb != 4'd8) && (pos == 4'd14);
            end else begin
              bit_count <= bit_count + 64'd64;
            end
            if (pos == 4'd15) begin
              state <= S_ROUND;
              for (int i = 0; i < 8; i++) begin
                v[i] <= hash[i];
              end
            end else if (in_data.last) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_marker_pending <= 1'b0;
          pos <= pos + 4'd1;
          if (pos == 4'd15) begin
            // block full: length placed here unless the marker came too late
            pad_late <= 1'b0;
            if (!pad_marker_pending && !pad_late) begin
              pad_len_pending <= 1'b0;
            end
            state <= S_ROUND;
            for (int i = 0; i < 8; i++) begin
              v[i] <= hash[i];
            end
          end else if (pad_marker_pending) begin
            pad_late <= (pos == 4'd14);
          end
        end
        S_ROUND: begin
          phase <= phase + 2'd1;
          if (phase == 2'd2) begin
            t1_part <= v[7] + sha512_pkg::bsig1(v[4]) +
                       ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha512_pkg::round_k(round);
          end
          if (step) begin
            v[7]  <= v[6];
            v[6]  <= v[5];
            v[5]  <= v[4];
            v[4]  <= v[3] + t1;
            v[3]  <= v[2];
            v[2]  <= v[1];
            v[1]  <= v[0];
            v[0]  <= t1 + t2;
            round <= round + 7'd1;
            if (round == 7'(sha512_pkg::Rounds - 1)) begin
              state <= S_FINAL;
            end
          end
        end
        S_FINAL: begin
          round <= '0;
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + v[i];
          end
          if (!finishing) begin
            state <= S_GATHER;
          end else if (pad_len_pending) begin
            state <= S_PAD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state     <= S_GATHER;
              finishing <= 1'b0;
              pos       <= '0;
              bit_count <= '0;
              for (int i = 0; i < 8; i++) begin
                hash[i] <= sha512_pkg::init_hash(3'(i));
              end
            end
          end
        end
        default: state <= S_GATHER;
      endcase
    end
  end

endmodule

// File: rtl/core/sha512_checker.sv
// port-level checker for the sha-512 engine, bound to the top level
module sha512_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input sha512_pkg::out_item_t out_data
);

  // no input taken while digest words are offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready)) else $error("input ready during digest output");

  // digest words count up by one
  a_index_seq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.digest_last) |=>
      out_valid && (out_data.word_index == $past(out_data.word_index) + 3'd1))
    else $error("digest index skipped");

  // last flag only on index seven
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.digest_last == (out_data.word_index == 3'd7)))
    else $error("digest_last misplaced");

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

endmodule

bind sha512_hash_engine sha512_checker u_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
